@@ rtl/core/sgd_pkg.sv @@
package sgd_pkg;

    localparam int WINDOW         = 101;
    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_FRAC_BITS = 24;
    localparam int OUT_FRAC_BITS  = 24;

    localparam int HALF = (WINDOW - 1) / 2;

    // fixed widths of the channel fields and of the record counter
    localparam int SAMPLE_IN_W = 16;
    localparam int SLOPE_W     = 48;
    localparam int SEEN_W      = 8;

    localparam int TAP_W     = COEF_FRAC_BITS + 2;
    localparam int DIFF_W    = SAMPLE_WIDTH + 1;
    localparam int PROD_W    = DIFF_W + TAP_W;
    localparam int TREE_LVLS = $clog2(HALF);
    localparam int ACC_W     = PROD_W + TREE_LVLS;
    localparam int MAC_LAT   = 2 + TREE_LVLS;
    localparam int CNT_W     = $clog2(HALF + 2);
    localparam int RES_W     = ACC_W + 1 +
                               ((OUT_FRAC_BITS > COEF_FRAC_BITS) ?
                                (OUT_FRAC_BITS - COEF_FRAC_BITS) : 0);
    localparam int SAT_W     = ((RES_W > SLOPE_W) ? RES_W : SLOPE_W) + 1;

    localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};
    localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
    localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;

    typedef struct packed {
        logic             vld;
        logic             calc;   // window lies fully inside the record
        logic             last;
        logic [CNT_W-1:0] cnt;    // results this item gives
    } t_ctl;

    // cubic first-derivative tap for offset i, rounded half away from zero;
    // long division done by shift and subtract
    function automatic longint sgd_tap(int i);
        longint m;
        longint m2;
        longint m4;
        longint den;
        longint num;
        longint un;
        longint r;
        longint q;
        longint ii;
        logic   neg;
        int     b;
        m   = longint'(WINDOW);
        m2  = m * m;
        m4  = m2 * m2;
        ii  = longint'(i);
        den = m * (m2 - 1) * (3 * m4 - 39 * m2 + 108);
        num = 15 * (5 * (3 * m4 - 18 * m2 + 31) * ii
                    - 28 * (3 * m2 - 7) * ii * ii * ii);
        neg = num < 0;
        un  = neg ? -num : num;
        r   = 0;
        q   = 0;
        for (b = 62; b >= 0; b--) begin
            r = (r << 1) | ((un >> b) & 64'd1);
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        for (b = 0; b < COEF_FRAC_BITS; b++) begin
            q = q << 1;
            r = r << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        if (2 * r >= den) begin
            q = q + 1;
        end
        return neg ? -q : q;
    endfunction

endpackage

@@ rtl/core/sgd_channels.sv @@
interface sgd_in_if;
    import sgd_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_IN_W-1:0] sample;
    logic                          record_end;

    modport source (output valid, sample, record_end, input ready);
    modport sink   (input valid, sample, record_end, output ready);
endinterface

interface sgd_out_if;
    import sgd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [SLOPE_W-1:0] slope;
    logic                      run_last;

    modport source (output valid, slope, run_last, input ready);
    modport sink   (input valid, slope, run_last, output ready);
endinterface

@@ rtl/core/savitzky_golay_derivative_filter.sv @@
// path: delay line, then fold, product, adder-tree, slope and output registers
// throughput: one sample per cycle through the multiply-add pipeline unless the
// output stalls; a record end holds off input while the emitter sends its
// trailing zero results, one a cycle while the output is ready
// reset: synchronous, active low; clears valid bits, record counter and emitter
module savitzky_golay_derivative_filter (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sgd_in_if.sink    i_in,
    sgd_out_if.source o_out
);
    import sgd_pkg::*;

    t_sample                   r_dl [0:WINDOW-1];
    logic [SEEN_W-1:0]         r_seen;
    t_ctl                      r_ctl [0:MAC_LAT];
    t_ctl                      r_hd;
    t_ctl                      n_ctl;
    logic signed [SLOPE_W-1:0] r_slope;
    logic signed [SLOPE_W-1:0] n_slope;
    logic [CNT_W-1:0]          r_emit;
    logic                      r_o_valid;
    logic signed [SLOPE_W-1:0] r_o_slope;
    logic                      r_o_last;

    logic                      adv;
    logic                      accept;
    logic                      out_free;
    logic                      emit;
    logic                      last_idx;
    logic                      hd_done;
    logic                      has_res;
    logic signed [ACC_W-1:0]   w_sum;
    logic signed [RES_W-1:0]   w_res;
    logic signed [SAT_W-1:0]   w_wide;

    // ---------------- input side ----------------
    assign accept      = i_in.valid && adv;
    assign i_in.ready  = adv;
    assign has_res     = r_seen >= SEEN_W'(HALF);

    always_comb begin
        n_ctl.vld  = accept;
        n_ctl.calc = r_seen >= SEEN_W'(2 * HALF);
        n_ctl.last = i_in.record_end;
        n_ctl.cnt  = has_res ? CNT_W'(1) : '0;
        if (i_in.record_end) begin
            n_ctl.cnt = n_ctl.cnt + (has_res ? CNT_W'(HALF) : CNT_W'(r_seen + 1'b1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
        end else if (accept) begin
            if (i_in.record_end) begin
                r_seen <= '0;
            end else if (r_seen != SEEN_MAX) begin
                r_seen <= r_seen + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dl[0] <= i_in.sample[SAMPLE_WIDTH-1:0];
            for (int k = 1; k < WINDOW; k++) begin
                r_dl[k] <= r_dl[k-1];
            end
        end
    end

    // ---------------- multiply-add pipeline ----------------
    sgd_mac u_mac (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_win (r_dl),
        .o_sum (w_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= MAC_LAT; k++) begin
                r_ctl[k].vld <= 1'b0;
            end
            r_hd.vld <= 1'b0;
        end else if (adv) begin
            r_ctl[0] <= n_ctl;
            for (int k = 1; k <= MAC_LAT; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
            r_hd <= r_ctl[MAC_LAT];
        end
    end

    // ---------------- rescale and saturate ----------------
    if (COEF_FRAC_BITS > OUT_FRAC_BITS) begin : g_round
        localparam int SH = COEF_FRAC_BITS - OUT_FRAC_BITS;
        logic [ACC_W-1:0] w_mag;
        logic [ACC_W:0]   w_add;
        logic [ACC_W-1:0] w_rnd;

        always_comb begin
            w_mag = w_sum[ACC_W-1] ? ACC_W'(-w_sum) : ACC_W'(w_sum);
            w_add = {1'b0, w_mag} + ((ACC_W+1)'(1) << (SH - 1));
            w_rnd = ACC_W'(w_add >> SH);
            w_res = w_sum[ACC_W-1] ? -$signed({1'b0, w_rnd}) : $signed({1'b0, w_rnd});
        end
    end else begin : g_shift
        assign w_res = RES_W'(w_sum) <<< (OUT_FRAC_BITS - COEF_FRAC_BITS);
    end

    assign w_wide = SAT_W'(w_res);

    always_comb begin
        if (w_wide > SAT_W'(SLOPE_MAX)) begin
            n_slope = SLOPE_MAX;
        end else if (w_wide < SAT_W'(SLOPE_MIN)) begin
            n_slope = SLOPE_MIN;
        end else begin
            n_slope = SLOPE_W'(w_wide);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_slope <= n_slope;
        end
    end

    // ---------------- result emitter ----------------
    // the computed slope goes out only as the first result of an item
    assign out_free = !r_o_valid || o_out.ready;
    assign last_idx = r_emit == (r_hd.cnt - CNT_W'(1));
    assign emit     = r_hd.vld && (r_hd.cnt != '0) && out_free;
    assign hd_done  = r_hd.vld && ((r_hd.cnt == '0) || (out_free && last_idx));
    assign adv      = !r_hd.vld || hd_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_emit    <= last_idx ? '0 : r_emit + 1'b1;
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_slope <= ((r_emit == '0) && r_hd.calc) ? r_slope : '0;
            r_o_last  <= r_hd.last && last_idx;
        end
    end

    assign o_out.valid    = r_o_valid;
    assign o_out.slope    = r_o_slope;
    assign o_out.run_last = r_o_last;

`ifndef NO_ASSERTIONS
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hd.vld && (r_hd.cnt != '0) |-> r_emit < r_hd.cnt)
        else $error("emitter index ran past item result count");

    a_seen_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.record_end |=> r_seen == '0)
        else $error("record counter not cleared after record end");

    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && r_hd.last && last_idx |=> o_out.valid && o_out.run_last)
        else $error("final result of record not flagged");

    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hd.vld && (r_hd.cnt != '0) && !out_free |-> !i_in.ready)
        else $error("input taken while emitter is blocked");
`endif

endmodule

@@ rtl/core/sgd_mac.sv @@
module sgd_mac (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  sgd_pkg::t_sample                    i_win [0:sgd_pkg::WINDOW-1],
    output logic signed [sgd_pkg::ACC_W-1:0]    o_sum
);
    import sgd_pkg::*;

    logic signed [DIFF_W-1:0] r_diff [0:HALF-1];
    logic signed [ACC_W-1:0]  r_tree [0:TREE_LVLS][0:HALF-1];

    // antisymmetric taps: fold newer minus older sample around the centre
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < HALF; k++) begin
                r_diff[k] <= DIFF_W'(i_win[HALF-1-k]) - DIFF_W'(i_win[HALF+1+k]);
            end
        end
    end

    for (genvar k = 0; k < HALF; k++) begin : g_mul
        localparam logic signed [TAP_W-1:0] C_TAP = TAP_W'(sgd_tap(k + 1));
        logic signed [PROD_W-1:0] w_prod;

        assign w_prod = PROD_W'(r_diff[k]) * PROD_W'(C_TAP);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tree[0][k] <= ACC_W'(w_prod);
            end
        end
    end

    // registered pairwise adder tree
    for (genvar l = 1; l <= TREE_LVLS; l++) begin : g_lvl
        localparam int NP = (HALF + (1 << (l - 1)) - 1) >> (l - 1);
        localparam int NC = (NP + 1) >> 1;
        for (genvar k = 0; k < HALF; k++) begin : g_node
            if (k < NC) begin : g_used
                if (2 * k + 1 < NP) begin : g_add
                    always_ff @(posedge i_clk) begin
                        if (i_en) begin
                            r_tree[l][k] <= r_tree[l-1][2*k] + r_tree[l-1][2*k+1];
                        end
                    end
                end else begin : g_pass
                    always_ff @(posedge i_clk) begin
                        if (i_en) begin
                            r_tree[l][k] <= r_tree[l-1][2*k];
                        end
                    end
                end
            end else begin : g_idle
                always_ff @(posedge i_clk) begin
                    r_tree[l][k] <= '0;
                end
            end
        end
    end

    assign o_sum = r_tree[TREE_LVLS][0];

endmodule
